// ===== rtl/mts_pkg.sv =====
`timescale 1ns / 1ps

package mts_pkg;

	// Input opcodes, carried in s_tuser
	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_PAUSE = 3'd3,
		OP_WRITE = 3'd4
	} op_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MELODY_LENGTH = 2'd0,
		REG_TONE_GAP      = 2'd1,
		REG_TICK_RATE     = 2'd2
	} reg_idx_t;

	localparam logic [6:0]  RST_MELODY_LENGTH = 7'd1;
	localparam logic [15:0] RST_TONE_GAP      = 16'd0;
	localparam logic [19:0] RST_TICK_RATE     = 20'd1000;

	localparam logic [3:0]  REST_NOTE   = 4'd12;
	localparam logic [3:0]  OCTAVE_SAT  = 4'd10;
	localparam logic [21:0] FREQ_MAX_Q8 = 22'h3FFFFF;

	// Octave-4 pitches C4..B4 in units of 1e-10 Hz
	localparam logic [63:0] SCALE_DEC = 64'd10000000000;
	localparam logic [63:0] OCT4_FREQ [12] = '{
		64'd2616255653006, 64'd2771826309769, 64'd2936647679174, 64'd3111269837221,
		64'd3296275569129, 64'd3492282314330, 64'd3699944227116, 64'd3919954359817,
		64'd4153046975799, 64'd4400000000000, 64'd4661637615181, 64'd4938833012561
	};

	// One thousand times 2^31, the offset used by the wrap-safe deadline compare
	localparam logic [41:0] HALF_RANGE_X1000 = 42'd2147483648000;

	typedef logic [21:0] freq_t;
	typedef freq_t freq_tab_t [256];

	// Stored melody entry
	typedef struct packed {
		logic [15:0] dur_ms;
		logic [3:0]  octave;
		logic [3:0]  note;
	} entry_t;

	// Input payload as packed in s_tdata, lowest field last
	typedef struct packed {
		logic [15:0] entry_dur_ms;
		logic [3:0]  entry_octave;
		logic [3:0]  entry_note;
		logic [5:0]  entry_index;
		logic        pause_flag;
		logic        loop_flag;
		logic [31:0] cur_tick;
	} in_item_t;

	// Result payload as packed in m_tdata, lowest field last
	typedef struct packed {
		logic [6:0]  position;
		logic        is_paused;
		logic        playing;
		logic [21:0] tone_freq_q8;
		logic        tone_on;
	} result_t;

	// Deadline load command from the sequencer to the deadline unit
	typedef struct packed {
		logic        set;
		logic        exact;
		logic [31:0] base;
		logic [15:0] ms;
		logic [19:0] tf;
	} dl_set_t;

	// Q14.8 pitch for every {octave, note} code, rounded to nearest
	function automatic freq_tab_t build_freq_tab();
		freq_tab_t   tab;
		logic [63:0] v;
		logic [7:0]  code;
		logic [3:0]  note;
		logic [3:0]  oct;
		for (int i = 0; i < 256; i++) begin
			code = 8'(i);
			note = code[3:0];
			oct  = code[7:4];
			if (note >= REST_NOTE) begin
				tab[code] = '0;
			end else if (oct >= OCTAVE_SAT) begin
				tab[code] = FREQ_MAX_Q8;
			end else begin
				v = ((OCT4_FREQ[note] << (oct + 4'd4)) + SCALE_DEC / 2) / SCALE_DEC;
				tab[code] = (v > 64'(FREQ_MAX_Q8)) ? FREQ_MAX_Q8 : v[21:0];
			end
		end
		return tab;
	endfunction

	localparam freq_tab_t FREQ_TAB = build_freq_tab();

endpackage

// ===== rtl/melody_tone_sequencer.sv =====
`timescale 1ns / 1ps

// Melody tone sequencer. Commands arrive as transfers on the s_ side (tick,
// start, stop, pause or resume, table write, selected by s_tuser) and every
// command gives exactly one status transfer on the m_ side: tone enable,
// Q14.8 frequency, playing, paused and the next table position. The melody
// table sits in a single-port-read synchronous memory; it is not cleared at
// reset, so only entries that were written may be played. In a command's
// transfer cycle the table entry for the next tone is read; in its update,
// once the output register is free, the player state is updated and the
// result is loaded into the output register. A new command is taken in the
// cycle after that update, which also lets the deadline unit register the
// ms * tick rate product that the next end-of-tone test needs, so no command
// is taken before the last one has been updated. A status held by a
// stalled m_ side does not block the transfer of the next command; only
// its update and later commands wait for it. Configuration writes on cfg_we
// take effect at once and are meant for times when no command is in flight.
module melody_tone_sequencer #(
	parameter int MELODY_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_wdata,
	// Command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// cur_tick[31:0], loop_flag[32], pause_flag[33], entry_index[39:34],
	// entry_note[43:40], entry_octave[47:44], entry_dur_ms[63:48]
	input  logic [63:0] s_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_tuser,
	// Status stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// tone_on[0], tone_freq_q8[22:1], playing[23], is_paused[24], position[31:25]
	output logic [31:0] m_tdata
);

	localparam int AW        = (MELODY_DEPTH > 1) ? $clog2(MELODY_DEPTH) : 1;
	localparam int DEPTH_CAP = (MELODY_DEPTH > 127) ? 127 : MELODY_DEPTH;

	// Configuration registers
	logic [6:0]  melody_length_q;
	logic [15:0] tone_gap_q;
	logic [19:0] tick_rate_q;

	// Player state
	logic        active_q;
	logic        paused_q;
	logic        loop_q;
	logic        wait_tone_q;
	logic        wait_gap_q;
	logic [6:0]  tone_index_q;
	logic        tone_on_q;
	logic [21:0] tone_freq_q;

	// Command held during its update cycle
	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [31:0] now_s1;
	logic        loop_s1;
	logic        pause_s1;

	mts_pkg::in_item_t item;
	mts_pkg::entry_t   wr_entry;
	mts_pkg::entry_t   rd_entry;
	mts_pkg::result_t  result_q;
	mts_pkg::dl_set_t  dl_cmd;

	logic          accept;
	logic          commit;
	logic [6:0]    eff_len;
	logic          wr_en;
	logic [AW-1:0] rd_addr;
	logic          reached;

	// Next-state values of the update cycle
	logic        active_d;
	logic        paused_d;
	logic        loop_d;
	logic        wait_tone_d;
	logic        wait_gap_d;
	logic [6:0]  tone_index_d;
	logic        tone_on_d;
	logic [21:0] tone_freq_d;
	logic        run_adv;
	logic        play;
	logic        dl_req;
	logic        dl_exact;
	logic [15:0] dl_ms;
	mts_pkg::freq_t pitch;

	assign item     = s_tdata;
	assign s_tready = !valid_s1;
	assign accept   = s_tvalid && s_tready;
	assign commit   = valid_s1 && (!m_tvalid || m_tready);
	assign m_tdata  = result_q;

	// Entries in use, clipped to the table depth
	assign eff_len = (melody_length_q > 7'(DEPTH_CAP)) ? 7'(DEPTH_CAP) : melody_length_q;

	// ---------------------------------------------------------------------
	// Configuration
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			melody_length_q <= mts_pkg::RST_MELODY_LENGTH;
			tone_gap_q      <= mts_pkg::RST_TONE_GAP;
			tick_rate_q     <= mts_pkg::RST_TICK_RATE;
		end else if (cfg_we) begin
			case (cfg_index)
				mts_pkg::REG_MELODY_LENGTH: melody_length_q <= cfg_wdata[6:0];
				mts_pkg::REG_TONE_GAP:      tone_gap_q      <= cfg_wdata[15:0];
				mts_pkg::REG_TICK_RATE:     tick_rate_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Melody table. Writes land in the transfer cycle; the entry a tick or
	// start may play is read at the same edge, from the committed position
	// (rewound to the first entry on start or at the end of the table).
	// ---------------------------------------------------------------------
	assign wr_en = accept && (s_tuser == mts_pkg::OP_WRITE) &&
		(32'(item.entry_index) < 32'(MELODY_DEPTH));

	assign wr_entry.dur_ms = item.entry_dur_ms;
	assign wr_entry.octave = item.entry_octave;
	assign wr_entry.note   = item.entry_note;

	assign rd_addr = ((s_tuser == mts_pkg::OP_START) || (tone_index_q >= eff_len)) ?
		'0 : AW'(tone_index_q);

	mts_store #(
		.DEPTH (MELODY_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(item.entry_index)),
		.wdata (wr_entry),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_entry)
	);

	mts_deadline u_deadline (
		.clk     (clk),
		.arst_n  (arst_n),
		.set_cmd (dl_cmd),
		.now     (now_s1),
		.reached (reached)
	);

	// ---------------------------------------------------------------------
	// Command capture
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (commit) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= s_tuser;
			now_s1   <= item.cur_tick;
			loop_s1  <= item.loop_flag;
			pause_s1 <= item.pause_flag;
		end
	end

	// ---------------------------------------------------------------------
	// Update: command effect first, then the playback step for tick/start
	// ---------------------------------------------------------------------
	assign pitch = mts_pkg::FREQ_TAB[{rd_entry.octave, rd_entry.note}];

	always_comb begin
		active_d     = active_q;
		paused_d     = paused_q;
		loop_d       = loop_q;
		wait_tone_d  = wait_tone_q;
		wait_gap_d   = wait_gap_q;
		tone_index_d = tone_index_q;
		tone_on_d    = tone_on_q;
		tone_freq_d  = tone_freq_q;
		run_adv      = 1'b0;
		play         = 1'b0;
		dl_req       = 1'b0;
		dl_exact     = 1'b0;
		dl_ms        = '0;

		case (op_s1)
			mts_pkg::OP_TICK: begin
				run_adv = 1'b1;
			end
			mts_pkg::OP_START: begin
				// Ignore a start with no entries configured
				if (melody_length_q != '0) begin
					tone_index_d = '0;
					active_d     = 1'b1;
					paused_d     = 1'b0;
					loop_d       = loop_s1;
					wait_tone_d  = 1'b0;
					wait_gap_d   = 1'b0;
					tone_on_d    = 1'b0;
					tone_freq_d  = '0;
					dl_req       = 1'b1;
					dl_exact     = 1'b1;
					run_adv      = 1'b1;
				end
			end
			mts_pkg::OP_STOP: begin
				active_d     = 1'b0;
				paused_d     = 1'b0;
				wait_tone_d  = 1'b0;
				wait_gap_d   = 1'b0;
				tone_index_d = '0;
				tone_on_d    = 1'b0;
				tone_freq_d  = '0;
			end
			mts_pkg::OP_PAUSE: begin
				if (pause_s1) begin
					// Rewind a cut tone so that it replays on resume
					if (!paused_q) begin
						if (wait_tone_q && (tone_index_q != '0)) begin
							tone_index_d = tone_index_q - 7'd1;
						end
						wait_tone_d = 1'b0;
						wait_gap_d  = 1'b0;
						tone_on_d   = 1'b0;
						tone_freq_d = '0;
					end
					paused_d = 1'b1;
				end else begin
					// Resume: any pending wait ends on the next tick
					paused_d = 1'b0;
					dl_req   = 1'b1;
					dl_exact = 1'b1;
				end
			end
			default: ;
		endcase

		if (run_adv && active_d && !paused_d && !((wait_tone_d || wait_gap_d) && !reached)) begin
			play = 1'b1;
			if (wait_tone_d) begin
				tone_on_d   = 1'b0;
				tone_freq_d = '0;
				wait_tone_d = 1'b0;
				if (tone_gap_q != '0) begin
					wait_gap_d = 1'b1;
					dl_req     = 1'b1;
					dl_exact   = 1'b0;
					dl_ms      = tone_gap_q;
					play       = 1'b0;
				end
			end
			if (play) begin
				wait_gap_d = 1'b0;
				if (tone_index_d >= eff_len) begin
					if (loop_d && (eff_len != '0)) begin
						tone_index_d = '0;
					end else begin
						active_d    = 1'b0;
						tone_on_d   = 1'b0;
						tone_freq_d = '0;
						play        = 1'b0;
					end
				end
			end
			if (play) begin
				tone_index_d = tone_index_d + 7'd1;
				tone_on_d    = (pitch != '0);
				tone_freq_d  = pitch;
				wait_tone_d  = 1'b1;
				dl_req       = 1'b1;
				dl_exact     = 1'b0;
				dl_ms        = rd_entry.dur_ms;
			end
		end

		dl_cmd.set   = dl_req && commit;
		dl_cmd.exact = dl_exact;
		dl_cmd.base  = now_s1;
		dl_cmd.ms    = dl_ms;
		dl_cmd.tf    = tick_rate_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			paused_q     <= 1'b0;
			loop_q       <= 1'b0;
			wait_tone_q  <= 1'b0;
			wait_gap_q   <= 1'b0;
			tone_index_q <= '0;
			tone_on_q    <= 1'b0;
			tone_freq_q  <= '0;
		end else if (commit) begin
			active_q     <= active_d;
			paused_q     <= paused_d;
			loop_q       <= loop_d;
			wait_tone_q  <= wait_tone_d;
			wait_gap_q   <= wait_gap_d;
			tone_index_q <= tone_index_d;
			tone_on_q    <= tone_on_d;
			tone_freq_q  <= tone_freq_d;
		end
	end

	// ---------------------------------------------------------------------
	// Output register: hold the status until the m_ side takes it
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (commit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_q.tone_on      <= tone_on_d;
			result_q.tone_freq_q8 <= tone_freq_d;
			result_q.playing      <= active_d;
			result_q.is_paused    <= paused_d;
			result_q.position     <= tone_index_d;
		end
	end

endmodule

// ===== rtl/mts_store.sv =====
`timescale 1ns / 1ps

// Melody table: one write port, one registered read port
module mts_store #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  mts_pkg::entry_t   wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output mts_pkg::entry_t   rdata
);

	mts_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/mts_deadline.sv =====
`timescale 1ns / 1ps

// Holds the current deadline as a base tick plus an unscaled product
// ms * tick rate. The end test compares the elapsed ticks times 1000 with
// the product, so the ceiling division by 1000 never has to be formed.
module mts_deadline (
	input  logic             clk,
	input  logic             arst_n,
	input  mts_pkg::dl_set_t set_cmd,
	input  logic [31:0]      now,
	output logic             reached
);

	logic [31:0] base_q;
	logic [15:0] ms_q;
	logic [19:0] tf_q;
	logic        exact_q;
	logic [35:0] prod_q;

	logic [35:0] prod;
	logic [31:0] elapsed;
	logic [41:0] elapsed_x1000;
	logic [41:0] prod_ext;
	logic        not_early;
	logic        not_wrapped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			ms_q    <= '0;
			tf_q    <= '0;
			exact_q <= 1'b1;
			prod_q  <= '0;
		end else begin
			if (set_cmd.set) begin
				base_q  <= set_cmd.base;
				ms_q    <= set_cmd.ms;
				tf_q    <= set_cmd.tf;
				exact_q <= set_cmd.exact;
			end
			// Zero-length waits still last one tick
			if (exact_q) begin
				prod_q <= '0;
			end else if (prod == '0) begin
				prod_q <= 36'd1;
			end else begin
				prod_q <= prod;
			end
		end
	end

	assign prod          = 36'(ms_q) * 36'(tf_q);
	assign elapsed       = now - base_q;
	assign elapsed_x1000 = (42'(elapsed) << 10) - (42'(elapsed) << 4) - (42'(elapsed) << 3);
	assign prod_ext      = 42'(prod_q);

	// Reached when ceil(prod/1000) <= elapsed < ceil(prod/1000) + 2^31
	assign not_early   = prod_ext <= elapsed_x1000;
	assign not_wrapped = !elapsed[31] ||
		((prod_ext + mts_pkg::HALF_RANGE_X1000) > elapsed_x1000);
	assign reached     = not_early && not_wrapped;

endmodule

// ===== rtl/mts_checker.sv =====
`timescale 1ns / 1ps

module mts_props (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// A stalled status transfer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("status changed while stalled");

	// One command at a time: no transfer in the cycle after a transfer
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken during update cycle");

	// A sounding tone belongs to active, unpaused playback
	a_tone_needs_play: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[23] && !m_tdata[24] && (m_tdata[22:1] != '0))
		else $error("tone on outside active playback");

	// Silence reports a zero frequency
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[22:1] == '0))
		else $error("frequency set while silent");

endmodule

bind melody_tone_sequencer mts_props u_mts_props (.*);

// ===== tb/mts_checker.sv =====
`timescale 1ns / 1ps

module mts_checker #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	output int          fail_total,
	output int          outstanding
);

	// C4..B4 in units of 1e-10 Hz; higher octaves are left shifts
	localparam logic [63:0] C4_PITCH [12] = '{
		64'd2616255653006, 64'd2771826309769, 64'd2936647679174, 64'd3111269837221,
		64'd3296275569129, 64'd3492282314330, 64'd3699944227116, 64'd3919954359817,
		64'd4153046975799, 64'd4400000000000, 64'd4661637615181, 64'd4938833012561
	};
	localparam logic [63:0] PITCH_SCALE = 64'd10000000000;

	mts_pkg::entry_t  tune_slots [DEPTH];
	logic [6:0]       len_r;
	logic [15:0]      gap_r;
	logic [19:0]      tf_r;
	logic             run_r, hold_r, loop_r, in_tone, in_gap;
	logic [6:0]       next_pos;
	logic [31:0]      due_tick;
	logic             out_on;
	logic [21:0]      out_freq;
	mts_pkg::result_t status_q [$];
	int               fail_count = 0;

	assign fail_total = fail_count;

	task automatic report_error(string msg);
		$display("[%0t] status error: %s", $time, msg);
		fail_count++;
	endtask

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			report_error($sformatf("%s expected %0d, got %0d", name, want, got));
	endtask

	function automatic logic [21:0] pitch_q8(logic [3:0] note, logic [3:0] oct);
		logic [63:0] v;
		if (note >= mts_pkg::REST_NOTE) return '0;
		if (oct >= mts_pkg::OCTAVE_SAT) return mts_pkg::FREQ_MAX_Q8;
		v = ((C4_PITCH[note] << (oct + 4)) + PITCH_SCALE / 2) / PITCH_SCALE;
		return (v > 64'(mts_pkg::FREQ_MAX_Q8)) ? mts_pkg::FREQ_MAX_Q8 : v[21:0];
	endfunction

	function automatic logic [31:0] ticks_for(logic [15:0] ms);
		logic [63:0] t;
		t = (64'(ms) * 64'(tf_r) + 64'd999) / 64'd1000;
		return (t == 0) ? 32'd1 : t[31:0];
	endfunction

	function automatic logic deadline_hit(logic [31:0] now);
		logic [31:0] d;
		d = now - due_tick;
		return !d[31];
	endfunction

	task automatic silence();
		out_on = 1'b0;
		out_freq = '0;
	endtask

	// Move to the next tone or gap once the current wait has run out
	task automatic advance_player(logic [31:0] now);
		mts_pkg::entry_t e;
		logic [6:0]      lim;
		logic [21:0]     f;
		if (!run_r || hold_r) return;
		if ((in_tone || in_gap) && !deadline_hit(now)) return;
		if (in_tone) begin
			silence();
			in_tone = 1'b0;
			if (gap_r != 0) begin
				in_gap = 1'b1;
				due_tick = now + ticks_for(gap_r);
				return;
			end
		end
		in_gap = 1'b0;
		lim = (len_r > DEPTH) ? 7'(DEPTH) : len_r;
		if (next_pos >= lim) begin
			if (loop_r && lim != 0) begin
				next_pos = '0;
			end else begin
				run_r = 1'b0;
				silence();
				return;
			end
		end
		e = tune_slots[next_pos];
		next_pos++;
		f = pitch_q8(e.note, e.octave);
		out_on = (f != 0);
		out_freq = f;
		in_tone = 1'b1;
		due_tick = now + ticks_for(e.dur_ms);
	endtask

	task automatic step_player(logic [2:0] op, mts_pkg::in_item_t c);
		case (op)
			mts_pkg::OP_TICK: advance_player(c.cur_tick);
			mts_pkg::OP_START: begin
				if (len_r != 0) begin
					next_pos = '0;
					due_tick = c.cur_tick;
					run_r = 1'b1;
					hold_r = 1'b0;
					loop_r = c.loop_flag;
					in_tone = 1'b0;
					in_gap = 1'b0;
					silence();
					advance_player(c.cur_tick);
				end
			end
			mts_pkg::OP_STOP: begin
				run_r = 1'b0;
				hold_r = 1'b0;
				in_tone = 1'b0;
				in_gap = 1'b0;
				next_pos = '0;
				silence();
			end
			mts_pkg::OP_PAUSE: begin
				if (c.pause_flag) begin
					// rewind a cut tone so that it replays on resume
					if (!hold_r) begin
						if (in_tone && next_pos > 0) next_pos--;
						in_tone = 1'b0;
						in_gap = 1'b0;
						silence();
					end
					hold_r = 1'b1;
				end else begin
					hold_r = 1'b0;
					due_tick = c.cur_tick;
				end
			end
			mts_pkg::OP_WRITE: begin
				if (c.entry_index < DEPTH)
					tune_slots[c.entry_index] = {c.entry_dur_ms, c.entry_octave, c.entry_note};
			end
			default: ;
		endcase
		status_q.push_back('{position: next_pos, is_paused: hold_r, playing: run_r,
			tone_freq_q8: out_freq, tone_on: out_on});
	endtask

	always @(posedge clk or negedge arst_n) begin
		mts_pkg::result_t want;
		mts_pkg::result_t got;
		if (!arst_n) begin
			len_r = mts_pkg::RST_MELODY_LENGTH;
			gap_r = mts_pkg::RST_TONE_GAP;
			tf_r = mts_pkg::RST_TICK_RATE;
			run_r = 1'b0;
			hold_r = 1'b0;
			loop_r = 1'b0;
			in_tone = 1'b0;
			in_gap = 1'b0;
			next_pos = '0;
			due_tick = '0;
			silence();
			status_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mts_pkg::REG_MELODY_LENGTH: len_r = cfg_wdata[6:0];
					mts_pkg::REG_TONE_GAP:      gap_r = cfg_wdata[15:0];
					mts_pkg::REG_TICK_RATE:     tf_r = cfg_wdata;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				step_player(s_tuser, mts_pkg::in_item_t'(s_tdata));
			if (m_tvalid && m_tready) begin
				got = mts_pkg::result_t'(m_tdata);
				if (status_q.size() == 0) begin
					report_error($sformatf("status transfer %h with none pending", m_tdata));
				end else begin
					want = status_q.pop_front();
					compare_field("tone_on", 32'(want.tone_on), 32'(got.tone_on));
					compare_field("tone_freq_q8", 32'(want.tone_freq_q8),
						32'(got.tone_freq_q8));
					compare_field("playing", 32'(want.playing), 32'(got.playing));
					compare_field("is_paused", 32'(want.is_paused), 32'(got.is_paused));
					compare_field("position", 32'(want.position), 32'(got.position));
				end
			end
			outstanding <= status_q.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Top of the melody sequencer bench: drives commands and config writes,
// wiggles the status ready, and gives the verdict. Status checking lives in
// mts_checker, which watches the same wires.
module tb;

	localparam int DEPTH = 64;
	localparam int HOLD_CYCLES = 300;
	// opcodes the block must ignore
	localparam logic [2:0] OP_SPARE_LO = 3'(mts_pkg::OP_WRITE) + 3'd1;
	localparam logic [2:0] OP_SPARE_HI = 3'b111;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [19:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	int              fail_total;
	int              outstanding;
	int              stall_pct = 0;
	int              hold_ask = 0;
	logic [31:0]     tick_now = '0;
	bit [DEPTH-1:0]  slot_written = '0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	melody_tone_sequencer #(.MELODY_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	mts_checker #(.DEPTH(DEPTH)) status_watch (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.fail_total(fail_total), .outstanding(outstanding)
	);

	// Status side: random stalls, plus a long hold-off whenever hold_ask moves
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_ask != hold_seen) begin
				hold_seen = hold_ask;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Offer one command after a random idle spell and hold it until the transfer
	task automatic send_cmd(logic [2:0] op, mts_pkg::in_item_t c, int gap_pct);
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (op == mts_pkg::OP_WRITE) slot_written[c.entry_index] = 1'b1;
	endtask

	// Directed command, no idling; flag goes to both loop and pause bits
	task automatic issue(logic [2:0] op, logic [31:0] now, logic flag, logic [5:0] slot,
		logic [3:0] note, logic [3:0] oct, logic [15:0] ms);
		mts_pkg::in_item_t c;
		c = '0;
		c.cur_tick = now;
		c.loop_flag = flag;
		c.pause_flag = flag;
		c.entry_index = slot;
		c.entry_note = note;
		c.entry_octave = oct;
		c.entry_dur_ms = ms;
		send_cmd(op, c, 0);
	endtask

	// Drop valid, wait until every status has come back, then let the pipe settle
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_regs(logic [6:0] len, logic [15:0] gap, logic [19:0] tf);
		cfg_we <= 1'b1;
		cfg_index <= mts_pkg::REG_MELODY_LENGTH;
		cfg_wdata <= 20'(len);
		@(posedge clk);
		cfg_index <= mts_pkg::REG_TONE_GAP;
		cfg_wdata <= 20'(gap);
		@(posedge clk);
		cfg_index <= mts_pkg::REG_TICK_RATE;
		cfg_wdata <= tf;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly small steps of the tick count, some long jumps, a few stray values
	function automatic logic [31:0] bump_tick();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) tick_now += $urandom_range(0, 4);
		else if (r < 90) tick_now += $urandom_range(0, 2000);
		else if (r < 98) tick_now += $urandom_range(0, 70000000);
		else return $urandom;
		return tick_now;
	endfunction

	function automatic logic [15:0] pick_ms();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 16'($urandom_range(0, 12));
		if (r < 90) return 16'($urandom_range(0, 300));
		return 16'($urandom_range(0, 65535));
	endfunction

	// Only lengths that cover written slots, so no unwritten entry is ever played
	function automatic logic [6:0] pick_length();
		int prefix;
		prefix = 0;
		while (prefix < DEPTH && slot_written[prefix]) prefix++;
		if (prefix == DEPTH && $urandom_range(0, 3) == 0)
			return 7'($urandom_range(DEPTH + 1, 127));
		return 7'($urandom_range(1, prefix));
	endfunction

	task automatic run_phase(int n, int gap_pct, int stall);
		mts_pkg::in_item_t c;
		logic [2:0]        op;
		int                r;
		stall_pct <= stall;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			c = mts_pkg::in_item_t'({$urandom, $urandom});
			c.cur_tick = bump_tick();
			if (r < 55) op = mts_pkg::OP_TICK;
			else if (r < 62) op = mts_pkg::OP_START;
			else if (r < 66) op = mts_pkg::OP_STOP;
			else if (r < 76) op = mts_pkg::OP_PAUSE;
			else if (r < 95) begin
				op = mts_pkg::OP_WRITE;
				c.entry_dur_ms = pick_ms();
			end else begin
				op = OP_SPARE_LO + 3'($urandom_range(0, 2));
			end
			send_cmd(op, c, gap_pct);
		end
	endtask

	initial begin
		mts_pkg::in_item_t c;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: one slot, no gap, 1 kHz ticks
		issue(mts_pkg::OP_WRITE, 32'd0, 1'b0, 6'd0, 4'd9, 4'd4, 16'd5);
		issue(mts_pkg::OP_TICK, 32'd1, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(OP_SPARE_HI, 32'd2, 1'b1, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_START, 32'd100, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_TICK, 32'd104, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_TICK, 32'd105, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_WRITE, 32'd106, 1'b0, 6'd1, mts_pkg::REST_NOTE, 4'd0, 16'd0);
		issue(mts_pkg::OP_WRITE, 32'd106, 1'b0, 6'd2, 4'hF, 4'hF, 16'hFFFF);
		issue(mts_pkg::OP_WRITE, 32'd106, 1'b0, 6'd3, 4'd0, mts_pkg::OCTAVE_SAT, 16'd1);
		issue(mts_pkg::OP_WRITE, 32'd106, 1'b0, 6'd4, 4'd11, 4'd9, 16'd2);
		issue(mts_pkg::OP_WRITE, 32'd106, 1'b0, 6'd63, 4'd0, 4'd0, 16'd0);
		// pause while idle, pause again, resume, stop
		issue(mts_pkg::OP_PAUSE, 32'd200, 1'b1, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_PAUSE, 32'd201, 1'b1, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_PAUSE, 32'd202, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_STOP, 32'd203, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		drain();

		// Looping five-slot tune with a gap, started just short of the count wrap
		set_regs(7'd5, 16'd3, 20'd1000);
		issue(mts_pkg::OP_START, 32'hFFFF_FFFE, 1'b1, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_TICK, 32'd2, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_TICK, 32'd3, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_TICK, 32'd6, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_PAUSE, 32'd6, 1'b1, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_TICK, 32'd9, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_PAUSE, 32'd9, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_TICK, 32'd9, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_TICK, 32'd10, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_TICK, 32'd13, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_TICK, 32'd65548, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		issue(mts_pkg::OP_STOP, 32'd65549, 1'b0, 6'd0, 4'd0, 4'd0, 16'd0);
		drain();

		// Random traffic, no idling on either side
		tick_now = 32'hFFFF_F000;
		set_regs(pick_length(), 16'd0, 20'd1000);
		run_phase(90, 0, 0);
		drain();

		// Fill every slot so that lengths past the table depth become legal
		stall_pct <= 0;
		for (int i = 0; i < DEPTH; i++) begin
			c = mts_pkg::in_item_t'({$urandom, $urandom});
			c.cur_tick = bump_tick();
			c.entry_index = 6'(i);
			c.entry_dur_ms = pick_ms();
			send_cmd(mts_pkg::OP_WRITE, c, 54);
		end
		drain();

		// Length past depth, longest gap, slowest ticks; hold the status side off
		// for a long stretch while commands keep coming, then leave a loop running
		set_regs(7'd127, 16'hFFFF, 20'd1);
		run_phase(20, 0, 54);
		hold_ask <= hold_ask + 1;
		run_phase(69, 0, 54);
		c = mts_pkg::in_item_t'({$urandom, $urandom});
		c.cur_tick = bump_tick();
		c.loop_flag = 1'b1;
		send_cmd(mts_pkg::OP_START, c, 0);
		drain();

		// Zero length and zero tick rate: starts ignored, a running loop ends
		set_regs(7'd0, 16'd1, 20'd0);
		run_phase(90, 19, 19);
		drain();

		// Fastest nominal tick rate; the sender pauses until all status is back
		set_regs(7'd64, 16'($urandom), 20'd1000000);
		run_phase(45, 0, 0);
		drain();
		run_phase(45, 0, 0);
		drain();

		set_regs(pick_length(), 16'($urandom_range(0, 20)), 20'hFFFFF);
		run_phase(90, 54, 54);
		drain();

		set_regs(pick_length(), 16'($urandom_range(0, 20)), 20'($urandom_range(1, 5000)));
		run_phase(10, 19, 19);
		drain();

		repeat (10) @(posedge clk);
		if (fail_total == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#3000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
